[rtl/tsrq_pkg.sv]
`default_nettype none
package tsrq_pkg;

	localparam int KEY_W = 26;
	localparam int TAG_W = 16;

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [15:0] tag;
	} rec_t;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Control that every cell sees in the same cycle.
	typedef struct packed {
		logic insert;
		logic shift;
		rec_t rec;
	} cell_ctl_t;

	function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
		rec_key = {r.month, r.day, r.hour, r.minute, r.second};
	endfunction

endpackage
`default_nettype wire

[rtl/timestamp_record_sort_range_query_unit.sv]
`default_nettype none
// A load gives no beat, or, when the store is full, a full-status beat in the cycle after it.
// A query rotates the sorted chain once past cell 0 and is busy for the whole scan, and longer
// when the last record matches right after another match; matches leave one beat per cycle,
// each held until the following record is seen, or one empty beat follows the scan.
// One load per cycle while not busy; a new query only once busy is low; no receiver stall.
// Reset: arst_n clears every valid bit and the control; record payloads are not reset.
module timestamp_record_sort_range_query_unit
	import tsrq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [3:0]  month,
	input  wire logic [4:0]  day,
	input  wire logic [4:0]  hour,
	input  wire logic [5:0]  minute,
	input  wire logic [5:0]  second,
	input  wire logic [15:0] tag,
	input  wire logic [3:0]  end_month,
	input  wire logic [4:0]  end_day,
	output logic             out_valid,
	output logic [3:0]       out_month,
	output logic [4:0]       out_day,
	output logic [4:0]       out_hour,
	output logic [5:0]       out_minute,
	output logic [5:0]       out_second,
	output logic [15:0]      out_tag,
	output logic [1:0]       status,
	output logic             last
);

	localparam int SW = $clog2(DEPTH);

	logic             accept;
	logic             scan_q;
	logic [SW-1:0]    step_q;
	logic [8:0]       start_date_q;
	logic [8:0]       end_date_q;
	logic             found_q;
	rec_t             in_rec;
	cell_ctl_t        ctl;
	logic [DEPTH-1:0] v;
	logic [DEPTH-1:0] g;
	rec_t             r [DEPTH];
	logic             full;
	rec_t             head_rec;
	logic             head_valid;
	logic [8:0]       head_date;
	logic             in_range;
	logic             hold_q;
	rec_t             hold_rec_q;
	rec_t             o_rec_q;
	logic             o_valid_q;
	logic             o_last_q;
	status_t          o_stat_q;
	logic             scan_end;

	// The block stays busy after the scan while the last record, which matched
	// right after another match, is still held and has to follow it.
	assign busy   = scan_q || hold_q;
	assign accept = start && !busy;
	assign full   = v[DEPTH-1];

	assign in_rec = '{month: month, day: day, hour: hour, minute: minute,
		second: second, tag: tag};

	assign ctl.insert = accept && !func && !full;
	assign ctl.shift  = scan_q;
	assign ctl.rec    = in_rec;

	// The chain: cell 0 holds the smallest key. During a query every cell takes
	// its right neighbour and the last cell takes cell 0, so the whole store
	// passes cell 0 in ascending order and is back in place after DEPTH shifts.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				tsrq_cell u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(ctl),
					.prev_valid(1'b0), .prev_gt(1'b0), .prev_rec('0),
					.next_rec(r[gi+1]),
					.is_first(1'b1), .valid(v[gi]), .gt(g[gi]), .rec(r[gi]));
			end else begin : g_body
				tsrq_cell u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(ctl),
					.prev_valid(v[gi-1]), .prev_gt(g[gi-1]), .prev_rec(r[gi-1]),
					.next_rec(r[(gi+1) % DEPTH]),
					.is_first(1'b0), .valid(v[gi]), .gt(g[gi]), .rec(r[gi]));
			end
		end
	endgenerate

	// Valid bits do not rotate: after step_q shifts, cell 0 holds the record
	// that started in cell step_q, so that cell's valid bit qualifies it.
	assign head_rec   = r[0];
	assign head_valid = v[step_q];
	assign head_date  = {head_rec.month, head_rec.day};
	assign in_range   = head_valid && (head_date >= start_date_q)
		&& (head_date <= end_date_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= 1'b0;
			step_q  <= '0;
			found_q <= 1'b0;
		end else if (accept && func) begin
			scan_q  <= 1'b1;
			step_q  <= '0;
			found_q <= 1'b0;
		end else if (scan_q) begin
			if (in_range) begin
				found_q <= 1'b1;
			end
			if (step_q == SW'(DEPTH - 1)) begin
				scan_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func) begin
			start_date_q <= {month, day};
			end_date_q   <= {end_month, end_day};
		end
	end

	// Output register; a matching record is held until the following record is
	// seen so that the last flag can be decided. A record still held when the
	// scan ends leaves in the cycle after it, marked last.
	assign scan_end = scan_q && (step_q == SW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			o_valid_q <= 1'b0;
			if (accept && !func && full) begin
				o_valid_q <= 1'b1;
			end else if (scan_q) begin
				if (in_range) begin
					hold_q    <= !scan_end || hold_q;
					o_valid_q <= hold_q || scan_end;
				end else begin
					o_valid_q <= hold_q || (scan_end && !found_q);
					hold_q    <= 1'b0;
				end
			end else if (hold_q) begin
				o_valid_q <= 1'b1;
				hold_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !func && full) begin
			o_rec_q  <= in_rec;
			o_stat_q <= ST_FULL;
			o_last_q <= 1'b1;
		end else if (scan_q) begin
			if (in_range) begin
				hold_rec_q <= head_rec;
				o_rec_q    <= scan_end && !hold_q ? head_rec : hold_rec_q;
				o_last_q   <= scan_end && !hold_q;
				o_stat_q   <= ST_VALID;
			end else if (hold_q) begin
				o_rec_q  <= hold_rec_q;
				o_last_q <= 1'b1;
				o_stat_q <= ST_VALID;
			end else begin
				o_rec_q  <= '0;
				o_last_q <= 1'b1;
				o_stat_q <= ST_EMPTY;
			end
		end else if (hold_q) begin
			o_rec_q  <= hold_rec_q;
			o_last_q <= 1'b1;
			o_stat_q <= ST_VALID;
		end
	end

	assign out_valid  = o_valid_q;
	assign out_month  = o_rec_q.month;
	assign out_day    = o_rec_q.day;
	assign out_hour   = o_rec_q.hour;
	assign out_minute = o_rec_q.minute;
	assign out_second = o_rec_q.second;
	assign out_tag    = o_rec_q.tag;
	assign status     = o_stat_q;
	assign last       = o_last_q;

`ifndef NO_ASSERTIONS
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		v[DEPTH-1] |-> v[0]) else $error("valid bits not contiguous");
	a_no_insert_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q |-> !ctl.insert) else $error("insert during query");
	a_full_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !func && full) |=> (out_valid && status == ST_FULL))
		else $error("missing full beat");
`endif

endmodule
`default_nettype wire

[rtl/tsrq_cell.sv]
`default_nettype none
module tsrq_cell
	import tsrq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      prev_valid,
	input  wire logic      prev_gt,
	input  wire rec_t      prev_rec,
	input  wire rec_t      next_rec,
	input  wire logic      is_first,
	output logic           valid,
	output logic           gt,
	output rec_t           rec
);

	logic valid_q;
	rec_t rec_q;

	assign valid = valid_q;
	assign rec   = rec_q;
	// This cell's record sorts strictly after the incoming one.
	assign gt = valid_q && (rec_key(rec_q) > rec_key(ctl.rec));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && !valid_q && (is_first || prev_valid)) begin
			valid_q <= 1'b1;
		end
	end

	// Insertion: cells past the insertion point take their left neighbour;
	// the insertion point takes the new record. Queries rotate by one towards
	// cell 0, each cell taking its right neighbour.
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (gt || (!valid_q && (is_first || prev_valid))) begin
				if (!is_first && prev_gt) begin
					rec_q <= prev_rec;
				end else begin
					rec_q <= ctl.rec;
				end
			end
		end else if (ctl.shift) begin
			rec_q <= next_rec;
		end
	end

endmodule
`default_nettype wire
